>>> sv/v3a_pkg.sv
// Package for the 3-D vector unit: opcodes, payload structs, saturation helper.
// No dependencies; every other file but v3a_delay imports it.
package v3a_pkg;

	localparam int CW = 32;
	localparam int FB = 16;

	typedef enum logic [2:0] {
		OP_LENGTH  = 3'd0,
		OP_SCALE   = 3'd1,
		OP_UNIT    = 3'd2,
		OP_DOT     = 3'd3,
		OP_CROSS   = 3'd4,
		OP_PROJECT = 3'd5,
		OP_DIFF    = 3'd6,
		OP_SUM     = 3'd7
	} op_t;

	typedef struct packed {
		op_t                kind;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] az;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [31:0] bz;
		logic signed [31:0] factor;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [31:0] rz;
		logic signed [31:0] scalar;
		logic               saturated;
	} res_t;

	// Clamped value plus its overflow flag
	typedef struct packed {
		logic signed [31:0] v;
		logic               f;
	} sat_t;

	localparam logic signed [65:0] VMAX66 = 66'sd2147483647;
	localparam logic signed [65:0] VMIN66 = -66'sd2147483648;

	// Clamp a wide signed value to the component range
	function automatic sat_t sat66(input logic signed [65:0] x);
		sat_t r;
		if (x > VMAX66) begin
			r.v = 32'sh7FFFFFFF;
			r.f = 1'b1;
		end else if (x < VMIN66) begin
			r.v = 32'sh80000000;
			r.f = 1'b1;
		end else begin
			r.v = x[31:0];
			r.f = 1'b0;
		end
		return r;
	endfunction

endpackage

>>> sv/vector3_alu.sv
// 3-D vector unit, signed Q16.16. Throughput: one command per cycle; busy is always
// low. Latency is set by the 32-step square root (16 stages) and the 18-step unit
// divide (9 stages). The receiver cannot stall; done is high for one cycle per result.
// Reset clears the valid pipeline and done; payload registers are not reset.
module vector3_alu import v3a_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output res_t result
);

	logic signed [31:0] av [3];
	logic signed [31:0] bv [3];
	logic signed [63:0] p1_s1 [3];
	sat_t               early [3];
	sat_t               proj [3];
	logic signed [31:0] unit [3];
	logic signed [65:0] sum_s2;
	sat_t               dot_s3, dot_s27, len_sat;
	logic [31:0]        root_s18, root_s27;
	logic [2:0]         kind_raw;
	op_t                kind_s27;
	logic [26:0]        vld_q;
	logic               done_q;
	res_t               res_q, nxt;

	assign busy = 1'b0;

	assign av[0] = cmd.ax;
	assign av[1] = cmd.ay;
	assign av[2] = cmd.az;
	assign bv[0] = cmd.bx;
	assign bv[1] = cmd.by;
	assign bv[2] = cmd.bz;

	for (genvar i = 0; i < 3; i++) begin : g_lane
		v3a_lane u_lane (
			.clk(clk), .kind(cmd.kind),
			.ai(av[i]), .bi(bv[i]),
			.aj(av[(i+1)%3]), .bk(bv[(i+2)%3]),
			.ak(av[(i+2)%3]), .bj(bv[(i+1)%3]),
			.fac(cmd.factor), .dot_s3(dot_s3.v), .root_s18(root_s18),
			.p1_s1(p1_s1[i]), .early(early[i]), .proj(proj[i]), .unit(unit[i])
		);
	end

	// Merge lane products: dot sum and squared length
	always_ff @(posedge clk) begin
		sum_s2 <= 66'(p1_s1[0]) + 66'(p1_s1[1]) + 66'(p1_s1[2]);
		dot_s3 <= sat66(sum_s2 >>> FB);
	end

	v3a_sqrt u_sqrt (.clk(clk), .rad(sum_s2[63:0]), .root(root_s18));

	v3a_delay #(.W(3), .N(27)) u_kind_dly (.clk(clk), .d(cmd.kind), .q(kind_raw));
	v3a_delay #(.W($bits(sat_t)), .N(24)) u_dot_dly (.clk(clk), .d(dot_s3), .q(dot_s27));
	v3a_delay #(.W(32), .N(9)) u_root_dly (.clk(clk), .d(root_s18), .q(root_s27));

	assign kind_s27 = op_t'(kind_raw);
	assign len_sat  = sat66(66'({1'b0, root_s27}));

	// Select the final result by opcode
	always_comb begin
		nxt = '0;
		case (kind_s27)
			OP_LENGTH: begin
				nxt.scalar    = len_sat.v;
				nxt.saturated = len_sat.f;
			end
			OP_DOT: begin
				nxt.scalar    = dot_s27.v;
				nxt.saturated = dot_s27.f;
			end
			OP_UNIT: begin
				if (root_s27 != 32'd0) begin
					nxt.rx = unit[0];
					nxt.ry = unit[1];
					nxt.rz = unit[2];
				end
			end
			OP_PROJECT: begin
				nxt.rx        = proj[0].v;
				nxt.ry        = proj[1].v;
				nxt.rz        = proj[2].v;
				nxt.saturated = dot_s27.f | proj[0].f | proj[1].f | proj[2].f;
			end
			default: begin
				nxt.rx        = early[0].v;
				nxt.ry        = early[1].v;
				nxt.rz        = early[2].v;
				nxt.saturated = early[0].f | early[1].f | early[2].f;
			end
		endcase
	end

	// Advance the valid pipeline; drop nothing, the receiver always takes the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			done_q <= 1'b0;
		end else begin
			vld_q  <= {vld_q[25:0], start};
			done_q <= vld_q[26];
		end
	end

	always_ff @(posedge clk) begin
		res_q <= nxt;
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

>>> sv/v3a_delay.sv
// Fixed-length register delay line for payload alignment.
// Depends on nothing.
module v3a_delay #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] tap_q [N];

	// Advance every tap once per cycle
	always_ff @(posedge clk) begin
		tap_q[0] <= d;
		for (int i = 1; i < N; i++) begin
			tap_q[i] <= tap_q[i-1];
		end
	end

	assign q = tap_q[N-1];

endmodule

>>> sv/v3a_sqrt.sv
// Pipelined integer square root of a 64-bit radicand, two result bits per stage.
// Depends on v3a_pkg.
module v3a_sqrt import v3a_pkg::*; (
	input  logic        clk,
	input  logic [63:0] rad,
	output logic [31:0] root
);

	localparam int NST = 16;

	typedef struct packed {
		logic [32:0] rem;
		logic [31:0] rt;
		logic [63:0] rd;
	} sstg_t;

	// One restoring digit step
	function automatic sstg_t sstep(input sstg_t x);
		sstg_t       y;
		logic [34:0] r2;
		logic [34:0] t;
		r2 = {x.rem, x.rd[63:62]};
		t  = {1'b0, x.rt, 2'b01};
		y.rd = {x.rd[61:0], 2'b00};
		if (r2 >= t) begin
			y.rem = 33'(r2 - t);
			y.rt  = {x.rt[30:0], 1'b1};
		end else begin
			y.rem = r2[32:0];
			y.rt  = {x.rt[30:0], 1'b0};
		end
		return y;
	endfunction

	sstg_t stg_s [NST];
	sstg_t init;

	assign init = '{rem: '0, rt: '0, rd: rad};

	// Advance the root two bits per stage
	always_ff @(posedge clk) begin
		stg_s[0] <= sstep(sstep(init));
		for (int s = 1; s < NST; s++) begin
			stg_s[s] <= sstep(sstep(stg_s[s-1]));
		end
	end

	assign root = stg_s[NST-1].rt;

endmodule

>>> sv/v3a_div.sv
// Pipelined floor division a * 2^16 / den for unit vectors, two quotient bits
// per stage. Quotient magnitude is at most 2^16. Depends on v3a_pkg.
module v3a_div import v3a_pkg::*; (
	input  logic               clk,
	input  logic signed [31:0] a,
	input  logic        [31:0] den,
	output logic signed [31:0] quo
);

	localparam int QB  = 18;
	localparam int NST = 9;

	typedef struct packed {
		logic [32:0]   rem;
		logic [QB-1:0] q;
		logic [QB-1:0] low;
		logic [31:0]   dn;
		logic          neg;
	} dstg_t;

	// One restoring quotient step
	function automatic dstg_t dstep(input dstg_t x);
		dstg_t       y;
		logic [32:0] r;
		r     = {x.rem[31:0], x.low[QB-1]};
		y     = x;
		y.low = {x.low[QB-2:0], 1'b0};
		if (r >= {1'b0, x.dn}) begin
			y.rem = r - {1'b0, x.dn};
			y.q   = {x.q[QB-2:0], 1'b1};
		end else begin
			y.rem = r;
			y.q   = {x.q[QB-2:0], 1'b0};
		end
		return y;
	endfunction

	logic [46:0] mag;
	dstg_t       init;
	dstg_t       stg_s [NST];
	logic [QB-1:0] qf;

	// Negative numerators divide ~n and complement the quotient (floor)
	assign mag  = a[31] ? {~a[30:0], 16'hFFFF} : {a[30:0], 16'h0000};
	assign init = '{rem: {4'b0, mag[46:QB]}, q: '0, low: mag[QB-1:0], dn: den, neg: a[31]};

	always_ff @(posedge clk) begin
		stg_s[0] <= dstep(dstep(init));
		for (int s = 1; s < NST; s++) begin
			stg_s[s] <= dstep(dstep(stg_s[s-1]));
		end
	end

	assign qf  = stg_s[NST-1].q;
	assign quo = stg_s[NST-1].neg ? ~{14'b0, qf} : {14'b0, qf};

endmodule

>>> sv/v3a_lane.sv
// One component lane: products, early results, project correction and unit divide.
// Depends on v3a_pkg, v3a_delay and v3a_div.
module v3a_lane import v3a_pkg::*; (
	input  logic               clk,
	input  op_t                kind,
	input  logic signed [31:0] ai,
	input  logic signed [31:0] bi,
	input  logic signed [31:0] aj,
	input  logic signed [31:0] bk,
	input  logic signed [31:0] ak,
	input  logic signed [31:0] bj,
	input  logic signed [31:0] fac,
	input  logic signed [31:0] dot_s3,
	input  logic        [31:0] root_s18,
	output logic signed [63:0] p1_s1,
	output sat_t               early,
	output sat_t               proj,
	output logic signed [31:0] unit
);

	logic signed [31:0] m1a, m1b;
	logic signed [63:0] p2_s1;
	op_t                kind_s1;
	logic signed [31:0] a_s1, b_s1, a_s2, b_s2, a_s3, b_s3, b_s4;
	sat_t               er_c, er_s2, pj_c, pj_s5;
	logic signed [63:0] prod_s4;
	logic signed [31:0] a_s18;

	// Pick the first multiplier's operands by opcode
	always_comb begin
		case (kind)
			OP_SCALE: begin
				m1a = ai;
				m1b = fac;
			end
			OP_CROSS: begin
				m1a = aj;
				m1b = bk;
			end
			OP_DOT, OP_PROJECT: begin
				m1a = ai;
				m1b = bi;
			end
			default: begin
				m1a = ai;
				m1b = ai;
			end
		endcase
	end

	// Stage 1: products; hold operands for later stages
	always_ff @(posedge clk) begin
		p1_s1   <= m1a * m1b;
		p2_s1   <= ak * bj;
		kind_s1 <= kind;
		a_s1    <= ai;
		b_s1    <= bi;
		a_s2    <= a_s1;
		b_s2    <= b_s1;
		a_s3    <= a_s2;
		b_s3    <= b_s2;
		b_s4    <= b_s3;
	end

	// Early results: scale, cross, diff, sum
	always_comb begin
		case (kind_s1)
			OP_SCALE: er_c = sat66(66'(p1_s1 >>> FB));
			OP_CROSS: er_c = sat66(66'((65'(p1_s1) - 65'(p2_s1)) >>> FB));
			OP_DIFF:  er_c = sat66(66'(33'(a_s1) - 33'(b_s1)));
			OP_SUM:   er_c = sat66(66'(33'(a_s1) + 33'(b_s1)));
			default:  er_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		er_s2 <= er_c;
	end

	// Project: b - floor(d * a)
	assign pj_c = sat66(66'(49'(b_s4) - 49'(prod_s4 >>> FB)));

	always_ff @(posedge clk) begin
		prod_s4 <= dot_s3 * a_s3;
		pj_s5   <= pj_c;
	end

	v3a_delay #(.W($bits(sat_t)), .N(25)) u_er_dly (.clk(clk), .d(er_s2), .q(early));
	v3a_delay #(.W($bits(sat_t)), .N(22)) u_pj_dly (.clk(clk), .d(pj_s5), .q(proj));
	v3a_delay #(.W(32), .N(15)) u_a_dly (.clk(clk), .d(a_s3), .q(a_s18));

	v3a_div u_div (.clk(clk), .a(a_s18), .den(root_s18), .quo(unit));

endmodule

>>> bench/tb.sv
// Testbench for vector3_alu: directed and random commands, results checked
// against an internal predictor. Depends on v3a_pkg and vector3_alu.
`timescale 1ns / 100ps

module tb;
	import v3a_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	logic done;
	res_t result;

	res_t expected_q[$];
	int accepted;
	int errors;
	int cycles;

	vector3_alu dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result)
	);

	// Clock, period 4 ns
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Clamp a wide value to the component range, raise the flag on overflow
	function automatic logic signed [31:0] clamp_comp(input logic signed [65:0] x,
		inout logic f);
		if (x > 66'sd2147483647) begin
			f = 1'b1;
			return 32'sh7FFFFFFF;
		end
		if (x < -66'sd2147483648) begin
			f = 1'b1;
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

	// Integer square root of an unsigned 64-bit value
	function automatic logic [63:0] root64(input logic [63:0] s);
		logic [63:0] res;
		logic [63:0] b_;
		res = 64'd0;
		b_ = 64'd1 << 62;
		while (b_ > s)
			b_ = b_ >> 2;
		while (b_ != 64'd0) begin
			if (s >= res + b_) begin
				s = s - (res + b_);
				res = (res >> 1) + b_;
			end else begin
				res = res >> 1;
			end
			b_ = b_ >> 2;
		end
		return res;
	endfunction

	// Floor division, divisor positive
	function automatic longint floor_div(input longint n, input longint d);
		if (n >= 0)
			return n / d;
		return -((-(n + 1)) / d) - 1;
	endfunction

	// Work out the result of one command
	function automatic res_t vector_result(input cmd_t c);
		res_t r;
		logic f;
		longint a[3];
		longint b[3];
		longint fac;
		logic [63:0] sq;
		logic [63:0] len;
		logic signed [65:0] acc;
		logic signed [65:0] p0;
		logic signed [65:0] p1;
		logic signed [31:0] d;
		logic signed [31:0] v[3];
		int j;
		int k;
		f = 1'b0;
		a[0] = c.ax; a[1] = c.ay; a[2] = c.az;
		b[0] = c.bx; b[1] = c.by; b[2] = c.bz;
		fac = c.factor;
		v[0] = 0; v[1] = 0; v[2] = 0;
		r.scalar = 0;
		case (c.kind)
			OP_LENGTH, OP_UNIT: begin
				sq = 64'd0;
				for (int i = 0; i < 3; i++)
					sq = sq + 64'(a[i] * a[i]);
				len = root64(sq);
				if (c.kind == OP_LENGTH) begin
					r.scalar = clamp_comp($signed({2'b00, len}), f);
				end else if (len != 64'd0) begin
					for (int i = 0; i < 3; i++)
						v[i] = clamp_comp(66'(floor_div(a[i] * 65536, longint'(len))), f);
				end
			end
			OP_SCALE: begin
				for (int i = 0; i < 3; i++)
					v[i] = clamp_comp(66'((a[i] * fac) >>> FB), f);
			end
			OP_DOT, OP_PROJECT: begin
				acc = 0;
				for (int i = 0; i < 3; i++) begin
					p0 = a[i] * b[i];
					acc = acc + p0;
				end
				d = clamp_comp(acc >>> FB, f);
				if (c.kind == OP_DOT) begin
					r.scalar = d;
				end else begin
					for (int i = 0; i < 3; i++) begin
						p0 = b[i];
						p1 = (longint'(d) * a[i]) >>> FB;
						v[i] = clamp_comp(p0 - p1, f);
					end
				end
			end
			OP_CROSS: begin
				for (int i = 0; i < 3; i++) begin
					j = (i + 1) % 3;
					k = (i + 2) % 3;
					p0 = a[j] * b[k];
					p1 = a[k] * b[j];
					v[i] = clamp_comp((p0 - p1) >>> FB, f);
				end
			end
			OP_DIFF: begin
				for (int i = 0; i < 3; i++) begin
					p0 = a[i];
					p1 = b[i];
					v[i] = clamp_comp(p0 - p1, f);
				end
			end
			default: begin
				for (int i = 0; i < 3; i++) begin
					p0 = a[i];
					p1 = b[i];
					v[i] = clamp_comp(p0 + p1, f);
				end
			end
		endcase
		r.rx = v[0];
		r.ry = v[1];
		r.rz = v[2];
		r.saturated = f;
		return r;
	endfunction

	// Print one mismatch and count it
	task automatic report_mismatch(input string field, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch at cycle %0d: %s got %h expected %h", cycles, field, got, want);
		errors++;
	endtask

	// Queue the expected result of each transfer, check each result
	always @(posedge clk) begin
		res_t w;
		if (arst_n) begin
			if (start && !busy) begin
				expected_q.push_back(vector_result(cmd));
				accepted++;
			end
			if (done) begin
				if (expected_q.size() == 0) begin
					$display("unexpected result at cycle %0d", cycles);
					errors++;
				end else begin
					w = expected_q.pop_front();
					if (result.rx !== w.rx) report_mismatch("rx", result.rx, w.rx);
					if (result.ry !== w.ry) report_mismatch("ry", result.ry, w.ry);
					if (result.rz !== w.rz) report_mismatch("rz", result.rz, w.rz);
					if (result.scalar !== w.scalar)
						report_mismatch("scalar", result.scalar, w.scalar);
					if (result.saturated !== w.saturated)
						report_mismatch("saturated", 32'(result.saturated), 32'(w.saturated));
				end
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** vector3_alu: FAILED **");
			$finish;
		end
	end

	// Send one command after a random gap; hold until it is taken
	task automatic send_cmd(input cmd_t c);
		int gap;
		int n;
		gap = $urandom_range(13);
		if ($urandom_range(3) == 0)
			gap = 0;
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		cmd = c;
		n = accepted;
		do
			@(negedge clk);
		while (accepted == n);
	endtask

	// Draw a component: small, mid-range, large, full range or an extreme
	function automatic logic signed [31:0] rand_comp();
		case ($urandom_range(5))
			0: return $signed($urandom_range(32'h0003FFFF)) - 32'sh0001FFFF;
			1: return $signed($urandom_range(32'h00FFFFFF)) - 32'sh007FFFFF;
			2: return $urandom_range(1) ? 32'sh7FFFFFFF - $urandom_range(3)
				: 32'sh80000000 + $urandom_range(3);
			3: return $signed($urandom_range(32'h1FFFFFFF)) - 32'sh0FFFFFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic cmd_t make_cmd(input op_t k, input logic signed [31:0] ax,
		input logic signed [31:0] ay, input logic signed [31:0] az,
		input logic signed [31:0] bx, input logic signed [31:0] by,
		input logic signed [31:0] bz, input logic signed [31:0] fac);
		cmd_t c;
		c.kind = k;
		c.ax = ax; c.ay = ay; c.az = az;
		c.bx = bx; c.by = by; c.bz = bz;
		c.factor = fac;
		return c;
	endfunction

	// Every opcode at the field extremes
	task automatic test_extremes();
		for (int k = 0; k < 8; k++) begin
			send_cmd(make_cmd(op_t'(k), 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
				32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000));
			send_cmd(make_cmd(op_t'(k), 32'sh80000000, 32'sh80000000, 32'sh80000000,
				32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF));
		end
	endtask

	// Unit of the zero vector, plain unit values, lengths of zero and one, a scale and a project
	task automatic test_unit_cases();
		send_cmd(make_cmd(OP_UNIT, 0, 0, 0, 32'sh12345, -32'sh777, 1, 32'sh10000));
		send_cmd(make_cmd(OP_UNIT, 1, 0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(OP_UNIT, -32'sh30000, 32'sh40000, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(OP_LENGTH, 0, 0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(OP_LENGTH, 32'sh10000, 0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(OP_SCALE, -1, 1, -32'sh10000, 0, 0, 0, 32'sh8000));
		send_cmd(make_cmd(OP_PROJECT, 32'sh10000, 0, 0, 32'sh20000, 32'sh30000, -5,
			32'sh10000));
	endtask

	// Random commands with random gaps
	task automatic test_random(input int count);
		for (int i = 0; i < count; i++)
			send_cmd(make_cmd(op_t'($urandom_range(7)), rand_comp(), rand_comp(),
				rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp()));
	endtask

	initial begin
		start = 1'b0;
		cmd = '0;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_extremes();
		test_unit_cases();
		test_random(1850);
		start = 1'b0;
		// Drain the pipeline
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && expected_q.size() == 0)
			$display("** vector3_alu: PASSED **");
		else
			$display("** vector3_alu: FAILED **");
		$finish;
	end

endmodule
